// ===== design/first_fit_free_list_allocator_core_defines.svh =====
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffa check failed");

// Next-cycle implication, disabled while in reset.
`define FFA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffa check failed");

`endif

// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Types, codes and sizes shared by the first-fit allocator files.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_UNITS       = 4096;
    localparam int UNIT_BYTES       = 16;
    localparam int ADDR_W           = $clog2(HEAP_UNITS);
    localparam int SIZE_W           = ADDR_W + 1;
    localparam int UNIT_SHIFT       = $clog2(UNIT_BYTES);
    localparam int GROW_DEFAULT     = 1024;
    localparam int FREE_WALK_LIMIT  = HEAP_UNITS + 2;
    localparam int ALLOC_WALK_LIMIT = 3 * HEAP_UNITS + 8;
    localparam int RWALK_W          = $clog2(FREE_WALK_LIMIT + 1);
    localparam int AWALK_W          = $clog2(ALLOC_WALK_LIMIT + 1);

    localparam logic [1:0] KIND_MALLOC = 2'd0;
    localparam logic [1:0] KIND_CALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;

    localparam logic [1:0] STAT_ALLOC  = 2'd0;
    localparam logic [1:0] STAT_OOM    = 2'd1;
    localparam logic [1:0] STAT_FREED  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [15:0]       count;
        logic [15:0]       elem_size;
        logic [ADDR_W-1:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] payload_unit;
        logic [SIZE_W-1:0] block_units;
        logic              zero_fill;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_UNITS,
        ST_A_RDP,
        ST_A_GETC,
        ST_A_CHK,
        ST_A_CARVE,
        ST_R_RD,
        ST_R_CHK,
        ST_R_RDA,
        ST_R_MRG1,
        ST_R_MRG2
    } state_t;

endpackage

// ===== design/first_fit_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// Header-unit first-fit allocator with an address-ordered circular free list.
// ----------------------------------------------------------------------------
//  channel   signals                      handshake
//  request   start, busy, request         taken when start && !busy
//  result    done, result                 one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data  written when valid && ready
//
// An item is first decoded (multiply, unit count). An allocation then reads
// the rover and its link, checks headers in turn and carves when the fit is
// not exact. A release (free or heap growth) walks the list node by node,
// then merges adjacent neighbours; after a growth the search restarts at
// the rover. The result strobe follows the last busy cycle. Reset is async;
// the header store is not cleared. The result strobe cannot be stalled.
module first_fit_free_list_allocator_core
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output rsp_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);

    localparam int UF_W = 33 - UNIT_SHIFT;

    state_t state_reg, state_next;

    req_t              req_reg, req_next;
    logic [31:0]       bytes_reg, bytes_next;
    logic [SIZE_W-1:0] units_reg, units_next;
    logic [ADDR_W-1:0] rover_reg, rover_next;
    logic              list_ready_reg, list_ready_next;
    logic [SIZE_W-1:0] heap_top_reg, heap_top_next;
    logic [12:0]       grow_min_reg;
    logic [ADDR_W-1:0] p_reg, p_next;
    logic [ADDR_W-1:0] hdr_reg, hdr_next;
    logic [ADDR_W-1:0] after_reg, after_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic [SIZE_W-1:0] psize_reg, psize_next;
    logic [SIZE_W-1:0] hsize_reg, hsize_next;
    logic [SIZE_W-1:0] nhsize_reg, nhsize_next;
    logic [ADDR_W-1:0] nhnext_reg, nhnext_next;
    logic [SIZE_W:0]   grant_reg, grant_next;
    logic [RWALK_W-1:0] rwalk_reg, rwalk_next;
    logic [AWALK_W-1:0] awalk_reg, awalk_next;
    logic              ret_grow_reg, ret_grow_next;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic              fin;
    rsp_t              fin_rsp;

    logic [ADDR_W-1:0] mem_addr;
    logic              nxt_we, sz_we;
    logic [ADDR_W-1:0] nxt_wd, rd_next;
    logic [SIZE_W-1:0] sz_wd, rd_size;

    logic [UF_W-1:0]    units_full;
    logic               too_big;
    logic               rel_hit;
    logic [RWALK_W-1:0] rwalk_inc;
    logic               rwalk_end;
    logic [AWALK_W-1:0] awalk_inc;
    logic               awalk_end;
    logic               fit, exact, at_rover;
    logic [SIZE_W-1:0]  grow_nu;
    logic               grow_ok;
    logic [SIZE_W-1:0]  carve_rest;
    logic [SIZE_W:0]    carve_hdr;
    logic               merge_after, merge_prev;
    logic [ADDR_W-1:0]  free_hdr;
    logic               free_ok;
    logic [SIZE_W:0]    gnt_hdr;
    logic [SIZE_W:0]    gnt_pay;
    rsp_t               gnt_rsp;
    logic               is_alloc;

    ffa_ram #(.DEPTH(HEAP_UNITS), .WIDTH(ADDR_W)) u_next_mem (
        .clk   (clk),
        .we    (nxt_we),
        .addr  (mem_addr),
        .wdata (nxt_wd),
        .rdata (rd_next)
    );

    ffa_ram #(.DEPTH(HEAP_UNITS), .WIDTH(SIZE_W)) u_size_mem (
        .clk   (clk),
        .we    (sz_we),
        .addr  (mem_addr),
        .wdata (sz_wd),
        .rdata (rd_size)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = rsp_reg;

    assign is_alloc   = (req_reg.kind == KIND_MALLOC) || (req_reg.kind == KIND_CALLOC);
    assign units_full = {1'b0, bytes_reg[31:UNIT_SHIFT]}
                      + UF_W'(|bytes_reg[UNIT_SHIFT-1:0]) + UF_W'(1);
    assign too_big    = units_full >= UF_W'(HEAP_UNITS);

    assign rel_hit = (hdr_reg > p_reg && hdr_reg < rd_next)
                  || (p_reg >= rd_next && (hdr_reg > p_reg || hdr_reg < rd_next));
    assign rwalk_inc = rwalk_reg + RWALK_W'(1);
    assign rwalk_end = rwalk_inc >= RWALK_W'(FREE_WALK_LIMIT);
    assign awalk_inc = awalk_reg + AWALK_W'(1);
    assign awalk_end = awalk_inc >= AWALK_W'(ALLOC_WALK_LIMIT);

    assign fit      = rd_size >= units_reg;
    assign exact    = rd_size == units_reg;
    assign at_rover = cur_reg == rover_reg;
    assign grow_nu  = (units_reg < grow_min_reg) ? grow_min_reg : units_reg;
    assign grow_ok  = ({1'b0, heap_top_reg} + {1'b0, grow_nu}) <= (SIZE_W + 1)'(HEAP_UNITS);

    assign carve_rest  = rd_size - units_reg;
    assign carve_hdr   = {2'b00, cur_reg} + {1'b0, carve_rest};
    assign merge_after = ({2'b00, hdr_reg} + {1'b0, hsize_reg}) == {2'b00, after_reg};
    assign merge_prev  = ({2'b00, p_reg} + {1'b0, psize_reg}) == {2'b00, hdr_reg};

    assign free_hdr = req_reg.block_addr - ADDR_W'(1);
    assign free_ok  = (req_reg.block_addr != '0) && (free_hdr != '0)
                   && ({1'b0, free_hdr} < heap_top_reg);

    // Grant header: exact fit in the check state, carved tail afterwards.
    assign gnt_hdr = (state_reg == ST_A_CARVE) ? grant_reg : {2'b00, cur_reg};
    assign gnt_pay = gnt_hdr + (SIZE_W + 1)'(1);

    always_comb
    begin
        gnt_rsp = '0;
        if (gnt_hdr != '0)
        begin
            gnt_rsp.status       = STAT_ALLOC;
            gnt_rsp.payload_unit = gnt_pay[ADDR_W-1:0];
            gnt_rsp.block_units  = units_reg;
            gnt_rsp.zero_fill    = (req_reg.kind == KIND_CALLOC) && (bytes_reg != '0);
        end
        else
        begin
            gnt_rsp.status = STAT_OOM;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UNITS;
            end
            ST_UNITS:
            begin
                if (req_reg.kind == KIND_FREE)
                begin
                    state_next = free_ok ? ST_R_RD : ST_IDLE;
                end
                else if (is_alloc && !too_big)
                begin
                    state_next = ST_A_RDP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_A_RDP:
            begin
                state_next = ST_A_GETC;
            end
            ST_A_GETC:
            begin
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                if (fit)
                begin
                    state_next = exact ? ST_IDLE : ST_A_CARVE;
                end
                else if (at_rover)
                begin
                    state_next = grow_ok ? ST_R_RD : ST_IDLE;
                end
                else
                begin
                    state_next = awalk_end ? ST_IDLE : ST_A_CHK;
                end
            end
            ST_A_CARVE:
            begin
                state_next = ST_IDLE;
            end
            ST_R_RD:
            begin
                state_next = ST_R_CHK;
            end
            ST_R_CHK:
            begin
                if (rel_hit)
                begin
                    state_next = ST_R_RDA;
                end
                else if (rwalk_end)
                begin
                    state_next = (ret_grow_reg && !awalk_end) ? ST_A_RDP : ST_IDLE;
                end
            end
            ST_R_RDA:
            begin
                state_next = ST_R_MRG1;
            end
            ST_R_MRG1:
            begin
                state_next = ST_R_MRG2;
            end
            ST_R_MRG2:
            begin
                state_next = (ret_grow_reg && !awalk_end) ? ST_A_RDP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory port and result
    always_comb
    begin
        req_next        = req_reg;
        bytes_next      = bytes_reg;
        units_next      = units_reg;
        rover_next      = rover_reg;
        list_ready_next = list_ready_reg;
        heap_top_next   = heap_top_reg;
        p_next          = p_reg;
        hdr_next        = hdr_reg;
        after_next      = after_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        psize_next      = psize_reg;
        hsize_next      = hsize_reg;
        nhsize_next     = nhsize_reg;
        nhnext_next     = nhnext_reg;
        grant_next      = grant_reg;
        rwalk_next      = rwalk_reg;
        awalk_next      = awalk_reg;
        ret_grow_next   = ret_grow_reg;
        mem_addr        = rover_reg;
        nxt_we          = 1'b0;
        nxt_wd          = '0;
        sz_we           = 1'b0;
        sz_wd           = '0;
        fin             = 1'b0;
        fin_rsp         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                end
            end
            ST_MUL:
            begin
                if (req_reg.kind == KIND_CALLOC)
                begin
                    bytes_next = 32'(req_reg.count) * 32'(req_reg.elem_size);
                end
                else
                begin
                    bytes_next = 32'(req_reg.count);
                end
            end
            ST_UNITS:
            begin
                units_next    = units_full[SIZE_W-1:0];
                p_next        = rover_reg;
                rwalk_next    = '0;
                awalk_next    = '0;
                ret_grow_next = 1'b0;
                hdr_next      = free_hdr;
                if (req_reg.kind == KIND_FREE)
                begin
                    if (!free_ok)
                    begin
                        fin            = 1'b1;
                        fin_rsp.status = STAT_FREED;
                    end
                end
                else if (is_alloc)
                begin
                    // Seed the anchor block on first use.
                    if (!list_ready_reg)
                    begin
                        mem_addr        = '0;
                        nxt_we          = 1'b1;
                        sz_we           = 1'b1;
                        list_ready_next = 1'b1;
                        rover_next      = '0;
                    end
                    if (too_big)
                    begin
                        fin            = 1'b1;
                        fin_rsp.status = STAT_OOM;
                    end
                end
                else
                begin
                    fin            = 1'b1;
                    fin_rsp.status = STAT_OOM;
                end
            end
            ST_A_RDP:
            begin
                mem_addr  = rover_reg;
                prev_next = rover_reg;
            end
            ST_A_GETC:
            begin
                cur_next = rd_next;
                mem_addr = rd_next;
            end
            ST_A_CHK:
            begin
                if (fit)
                begin
                    rover_next = prev_reg;
                    if (exact)
                    begin
                        mem_addr = prev_reg;
                        nxt_we   = 1'b1;
                        nxt_wd   = rd_next;
                        fin      = 1'b1;
                        fin_rsp  = gnt_rsp;
                    end
                    else
                    begin
                        mem_addr   = cur_reg;
                        sz_we      = 1'b1;
                        sz_wd      = carve_rest;
                        grant_next = carve_hdr;
                    end
                end
                else if (at_rover)
                begin
                    if (grow_ok)
                    begin
                        mem_addr      = heap_top_reg[ADDR_W-1:0];
                        sz_we         = 1'b1;
                        sz_wd         = grow_nu;
                        heap_top_next = heap_top_reg + grow_nu;
                        hdr_next      = heap_top_reg[ADDR_W-1:0];
                        p_next        = rover_reg;
                        rwalk_next    = '0;
                        ret_grow_next = 1'b1;
                    end
                    else
                    begin
                        fin            = 1'b1;
                        fin_rsp.status = STAT_OOM;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_next;
                    awalk_next = awalk_inc;
                    mem_addr   = rd_next;
                    if (awalk_end)
                    begin
                        fin            = 1'b1;
                        fin_rsp.status = STAT_OOM;
                    end
                end
            end
            ST_A_CARVE:
            begin
                // Drop the header write when the tail lands past the arena.
                mem_addr = grant_reg[ADDR_W-1:0];
                sz_we    = grant_reg < (SIZE_W + 1)'(HEAP_UNITS);
                sz_wd    = units_reg;
                fin      = 1'b1;
                fin_rsp  = gnt_rsp;
            end
            ST_R_RD:
            begin
                mem_addr = p_reg;
            end
            ST_R_CHK:
            begin
                if (rel_hit)
                begin
                    after_next = rd_next;
                    psize_next = rd_size;
                    mem_addr   = hdr_reg;
                end
                else
                begin
                    rwalk_next = rwalk_inc;
                    p_next     = rd_next;
                    mem_addr   = rd_next;
                    if (rwalk_end)
                    begin
                        p_next = p_reg;
                        if (ret_grow_reg)
                        begin
                            awalk_next = awalk_inc;
                            if (awalk_end)
                            begin
                                fin            = 1'b1;
                                fin_rsp.status = STAT_OOM;
                            end
                        end
                        else
                        begin
                            fin            = 1'b1;
                            fin_rsp.status = STAT_FREED;
                        end
                    end
                end
            end
            ST_R_RDA:
            begin
                hsize_next = rd_size;
                mem_addr   = after_reg;
            end
            ST_R_MRG1:
            begin
                mem_addr = hdr_reg;
                nxt_we   = 1'b1;
                if (merge_after)
                begin
                    nhsize_next = hsize_reg + rd_size;
                    nhnext_next = rd_next;
                    sz_we       = 1'b1;
                    sz_wd       = hsize_reg + rd_size;
                    nxt_wd      = rd_next;
                end
                else
                begin
                    nhsize_next = hsize_reg;
                    nhnext_next = after_reg;
                    nxt_wd      = after_reg;
                end
            end
            ST_R_MRG2:
            begin
                mem_addr   = p_reg;
                nxt_we     = 1'b1;
                rover_next = p_reg;
                if (merge_prev)
                begin
                    sz_we  = 1'b1;
                    sz_wd  = psize_reg + nhsize_reg;
                    nxt_wd = nhnext_reg;
                end
                else
                begin
                    nxt_wd = hdr_reg;
                end
                if (ret_grow_reg)
                begin
                    awalk_next = awalk_inc;
                    if (awalk_end)
                    begin
                        fin            = 1'b1;
                        fin_rsp.status = STAT_OOM;
                    end
                end
                else
                begin
                    fin            = 1'b1;
                    fin_rsp.status = STAT_FREED;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rover_reg      <= '0;
            list_ready_reg <= 1'b0;
            heap_top_reg   <= SIZE_W'(1);
            grow_min_reg   <= 13'(GROW_DEFAULT);
            rwalk_reg      <= '0;
            awalk_reg      <= '0;
            ret_grow_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rover_reg      <= rover_next;
            list_ready_reg <= list_ready_next;
            heap_top_reg   <= heap_top_next;
            rwalk_reg      <= rwalk_next;
            awalk_reg      <= awalk_next;
            ret_grow_reg   <= ret_grow_next;
            done_reg       <= fin;
            if (cfg_valid)
            begin
                grow_min_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        bytes_reg  <= bytes_next;
        units_reg  <= units_next;
        p_reg      <= p_next;
        hdr_reg    <= hdr_next;
        after_reg  <= after_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        psize_reg  <= psize_next;
        hsize_reg  <= hsize_next;
        nhsize_reg <= nhsize_next;
        nhnext_reg <= nhnext_next;
        grant_reg  <= grant_next;
        if (fin)
        begin
            rsp_reg <= fin_rsp;
        end
    end

endmodule

// ===== design/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_free_list_allocator_core_defines.svh"

module ffa_checker
    import ffa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t result
);

    `FFA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `FFA_ASSERT_IMP(a_done_idle, done, !busy)
    `FFA_ASSERT_IMP(a_status_code, done, result.status != 2'd3)
    `FFA_ASSERT_IMP(a_nogrant_zero, done && result.status != STAT_ALLOC,
        result.payload_unit == '0 && result.block_units == '0 && !result.zero_fill)
    // A grant at the last arena unit wraps its payload unit to zero.
    `FFA_ASSERT_IMP(a_grant_nonzero, done && result.status == STAT_ALLOC,
        result.block_units != '0)

endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== verif/tb_first_fit_free_list_allocator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator_core
// Drives malloc, calloc and free requests into the first-fit allocator. A
// shadow copy of the free list and headers predicts every result. The run
// walks through several grow minimums and several sender idle rates.
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator_core;
    import ffa_pkg::*;

    localparam int KIND_BAD = 3;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] count;
        logic [15:0] elem_size;
        logic [11:0] block_addr;
        bit          free_live;
        bit          typed;
        rsp_t        typed_rsp;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;

    // shadow allocator state
    int unsigned hdr_next[HEAP_UNITS];
    int unsigned hdr_size[HEAP_UNITS];
    int unsigned rover_q;
    bit          list_up;
    int unsigned heap_top_q;
    int unsigned grow_min;

    rsp_t        grant_q[$];
    logic [11:0] live_blocks[$];
    logic [11:0] freed_blocks[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_oom;
    int          n_grants;
    int          n_frees;
    int          idle_pct;
    int          quiet_cycles;

    first_fit_free_list_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned link_of(int unsigned i);
        return i < HEAP_UNITS ? hdr_next[i] : 0;
    endfunction

    function automatic int unsigned units_of(int unsigned i);
        return i < HEAP_UNITS ? hdr_size[i] : 0;
    endfunction

    function automatic void put_link(int unsigned i, int unsigned v);
        if (i < HEAP_UNITS)
        begin
            hdr_next[i] = v;
        end
    endfunction

    function automatic void put_units(int unsigned i, int unsigned v);
        if (i < HEAP_UNITS)
        begin
            hdr_size[i] = v;
        end
    endfunction

    // Insert a block into the address-ordered list, merging both neighbors.
    function automatic void insert_free(int unsigned hdr);
        int unsigned p;
        int unsigned n;
        int unsigned nxt;
        int unsigned walk;
        p = rover_q;
        walk = 0;
        forever
        begin
            n = link_of(p);
            if (hdr > p && hdr < n)
                break;
            if (p >= n && (hdr > p || hdr < n))
                break;
            walk++;
            if (walk >= FREE_WALK_LIMIT)
                return;
            p = n;
        end
        nxt = link_of(p);
        if (hdr + units_of(hdr) == nxt)
        begin
            put_units(hdr, units_of(hdr) + units_of(nxt));
            put_link(hdr, link_of(nxt));
        end
        else
            put_link(hdr, nxt);
        if (p + units_of(p) == hdr)
        begin
            put_units(p, units_of(p) + units_of(hdr));
            put_link(p, link_of(hdr));
        end
        else
            put_link(p, hdr);
        rover_q = p;
    endfunction

    function automatic bit grow_heap(longint unsigned units);
        longint unsigned nu;
        int unsigned hdr;
        nu = units < grow_min ? grow_min : units;
        hdr = heap_top_q;
        if (heap_top_q + nu > HEAP_UNITS)
            return 1'b0;
        put_units(hdr, int'(nu));
        heap_top_q = heap_top_q + int'(nu);
        insert_free(hdr);
        return 1'b1;
    endfunction

    // First-fit search from the rover; returns the granted header or 0.
    function automatic int unsigned find_fit(longint unsigned nbytes,
                                             output int unsigned granted);
        longint unsigned units;
        int unsigned prev;
        int unsigned cur;
        int unsigned rest;
        granted = 0;
        units = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
        if (!list_up)
        begin
            put_link(0, 0);
            put_units(0, 0);
            rover_q = 0;
            list_up = 1'b1;
        end
        if (units >= HEAP_UNITS)
            return 0;
        prev = rover_q;
        cur = link_of(prev);
        for (int walk = 0; walk < ALLOC_WALK_LIMIT; walk++)
        begin
            if (units_of(cur) >= units)
            begin
                if (units_of(cur) == units)
                    put_link(prev, link_of(cur));
                else
                begin
                    rest = units_of(cur) - int'(units);
                    put_units(cur, rest);
                    cur += rest;
                    put_units(cur, int'(units));
                end
                rover_q = prev;
                granted = int'(units);
                return cur;
            end
            if (cur == rover_q)
            begin
                if (!grow_heap(units))
                    return 0;
                cur = rover_q;
            end
            prev = cur;
            cur = link_of(cur);
        end
        return 0;
    endfunction

    function automatic rsp_t predict_grant(req_t rq);
        rsp_t r;
        longint unsigned nbytes;
        int unsigned hdr;
        int unsigned granted;
        r = '0;
        r.status = STAT_OOM;
        if (rq.kind == KIND_FREE)
        begin
            r.status = STAT_FREED;
            if (rq.block_addr != 0 && rq.block_addr - 1 >= 1
                && rq.block_addr - 1 < heap_top_q)
                insert_free(rq.block_addr - 1);
        end
        else if (rq.kind == KIND_MALLOC || rq.kind == KIND_CALLOC)
        begin
            nbytes = (rq.kind == KIND_MALLOC) ? longint'(rq.count)
                   : (longint'(rq.count) * longint'(rq.elem_size)) & 64'hFFFF_FFFF;
            hdr = find_fit(nbytes, granted);
            if (hdr != 0)
            begin
                r.status = STAT_ALLOC;
                r.payload_unit = hdr + 1;
                r.block_units = granted;
                r.zero_fill = (rq.kind == KIND_CALLOC && nbytes != 0);
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (grant_q.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                rsp_t e;
                e = grant_q.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, result.status);
                    errors++;
                end
                if (result.payload_unit !== e.payload_unit)
                begin
                    $error("payload_unit exp %0d got %0d", e.payload_unit,
                           result.payload_unit);
                    errors++;
                end
                if (result.block_units !== e.block_units)
                begin
                    $error("block_units exp %0d got %0d", e.block_units,
                           result.block_units);
                    errors++;
                end
                if (result.zero_fill !== e.zero_fill)
                begin
                    $error("zero_fill exp %0d got %0d", e.zero_fill, result.zero_fill);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_first_fit_free_list_allocator_core: FAIL");
            $finish;
        end
    end

    task automatic send_item(req_t rq);
        rsp_t e;
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        e = predict_grant(rq);
        grant_q.push_back(e);
        n_items++;
        case (e.status)
            STAT_ALLOC: begin n_grants++; live_blocks.push_back(e.payload_unit); end
            STAT_OOM:   n_oom++;
            default:    n_frees++;
        endcase
        // hold start high when the next item follows right away
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct && $urandom_range(7) != 0);
        end
    endtask

    task automatic drain_all();
        start <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_grow(logic [12:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        grow_min = v;
    endtask

    function automatic logic [11:0] take_live(bit newest);
        int idx;
        logic [11:0] a;
        idx = newest ? live_blocks.size() - 1 : $urandom_range(live_blocks.size() - 1);
        a = live_blocks[idx];
        live_blocks.delete(idx);
        freed_blocks.push_back(a);
        return a;
    endfunction

    function automatic req_t random_request(bit allow_double);
        req_t rq;
        int pick;
        rq.kind = KIND_MALLOC;
        rq.count = $urandom;
        rq.elem_size = $urandom;
        rq.block_addr = $urandom;
        pick = $urandom_range(99);
        if (pick < 40 || (pick < 80 && live_blocks.size() == 0))
        begin
            rq.kind = (pick % 3 == 0) ? KIND_CALLOC : KIND_MALLOC;
            case ($urandom_range(19))
                0:       ;
                1, 2, 3: begin rq.count = $urandom_range(4000);
                         rq.elem_size = $urandom_range(3); end
                default: begin rq.count = $urandom_range(200);
                         rq.elem_size = $urandom_range(12); end
            endcase
        end
        else if (pick < 80)
        begin
            rq.kind = KIND_FREE;
            rq.block_addr = take_live($urandom_range(3) == 0);
        end
        else if (pick < 96)
        begin
            rq.kind = KIND_MALLOC;
            rq.count = $urandom_range(48);
        end
        else if (pick < 98)
        begin
            // stray free outside the grown heap, or on the anchor
            rq.kind = KIND_FREE;
            if (heap_top_q < 4095 && $urandom_range(1))
                rq.block_addr = $urandom_range(4095, heap_top_q + 1);
            else
                rq.block_addr = $urandom_range(1);
        end
        else if (pick == 98 || !allow_double || freed_blocks.size() == 0)
            rq.kind = KIND_BAD;
        else
        begin
            rq.kind = KIND_FREE;
            rq.block_addr = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
        end
        return rq;
    endfunction

    stim_row_t stim_table[] = '{
        '{KIND_FREE,   16'd0,     16'd0,     12'd5,    0, 1, '{STAT_FREED, 0, 0, 0}},
        '{KIND_MALLOC, 16'hFFFF,  16'hFFFF,  12'hFFF,  0, 1, '{STAT_OOM, 0, 0, 0}},
        '{KIND_CALLOC, 16'hFFFF,  16'hFFFF,  12'd0,    0, 1, '{STAT_OOM, 0, 0, 0}},
        '{KIND_BAD,    16'hFFFF,  16'hFFFF,  12'hFFF,  0, 1, '{STAT_OOM, 0, 0, 0}},
        '{KIND_MALLOC, 16'd0,     16'd0,     12'd0,    0, 0, '0},
        '{KIND_MALLOC, 16'd1,     16'd0,     12'd0,    0, 0, '0},
        '{KIND_MALLOC, 16'd16,    16'd0,     12'd0,    0, 0, '0},
        '{KIND_MALLOC, 16'd17,    16'd0,     12'd0,    0, 0, '0},
        '{KIND_CALLOC, 16'd0,     16'd100,   12'd0,    0, 0, '0},
        '{KIND_CALLOC, 16'd3,     16'd7,     12'd0,    0, 0, '0},
        '{KIND_CALLOC, 16'd100,   16'd0,     12'd0,    0, 0, '0},
        '{KIND_MALLOC, 16'd4000,  16'd0,     12'd0,    0, 0, '0},
        '{KIND_FREE,   16'd0,     16'd0,     12'd0,    1, 0, '0},
        '{KIND_FREE,   16'd0,     16'd0,     12'd0,    1, 0, '0},
        '{KIND_FREE,   16'd0,     16'd0,     12'd1,    0, 1, '{STAT_FREED, 0, 0, 0}},
        '{KIND_FREE,   16'hFFFF,  16'hFFFF,  12'd4095, 0, 1, '{STAT_FREED, 0, 0, 0}},
        '{KIND_MALLOC, 16'd16,    16'd0,     12'd0,    0, 0, '0},
        '{KIND_CALLOC, 16'hFFFF,  16'd1,     12'd0,    0, 1, '{STAT_OOM, 0, 0, 0}},
        '{KIND_MALLOC, 16'd16367, 16'd0,     12'd0,    0, 0, '0},
        '{KIND_FREE,   16'd0,     16'd0,     12'd0,    1, 0, '0},
        '{KIND_CALLOC, 16'd1,     16'd65535, 12'd0,    0, 1, '{STAT_OOM, 0, 0, 0}}
    };

    int phase_idle[5] = '{0, 59, 0, 8, 59};
    logic [12:0] phase_grow[5] = '{13'd4096, 13'd1, 13'd37, 13'd1024, 13'd0};

    initial
    begin
        req_t rq;
        rsp_t e;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_oom = 0;
        n_grants = 0;
        n_frees = 0;
        idle_pct = 0;
        quiet_cycles = 0;
        for (int i = 0; i < HEAP_UNITS; i++)
        begin
            hdr_next[i] = 0;
            hdr_size[i] = 0;
        end
        rover_q = 0;
        list_up = 1'b0;
        heap_top_q = 1;
        grow_min = GROW_DEFAULT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            rq.kind = stim_table[i].kind;
            rq.count = stim_table[i].count;
            rq.elem_size = stim_table[i].elem_size;
            rq.block_addr = stim_table[i].block_addr;
            if (stim_table[i].free_live && live_blocks.size() != 0)
                rq.block_addr = take_live(i % 2 == 0);
            start <= 1'b1;
            request <= rq;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            e = predict_grant(rq);
            if (e.status == STAT_ALLOC)
                live_blocks.push_back(e.payload_unit);
            grant_q.push_back(stim_table[i].typed ? stim_table[i].typed_rsp : e);
            n_items++;
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            // sender waits here until every outstanding result is back
            drain_all();
            write_grow(phase_grow[ph] != 0 ? phase_grow[ph] : 13'($urandom_range(4096, 1)));
            idle_pct = phase_idle[ph];
            for (int k = 0; k < 350; k++)
            begin
                rq = random_request(ph == 4 && k > 300);
                if (ph == 4 && k > 300 && rq.kind == KIND_FREE && $urandom_range(3) == 0)
                    rq.block_addr = 12'd0;
                send_item(rq);
            end
        end
        drain_all();
        repeat (50) @(posedge clk);

        $display("Covered %0d requests (%0d results): %0d grants, %0d out of memory, %0d frees,",
                 n_items, n_results, n_grants, n_oom, n_frees);
        $display("five grow minimums and idle rates of 0, 8 and 59 percent.");
        if (errors == 0 && grant_q.size() == 0)
            $display("tb_first_fit_free_list_allocator_core: PASS");
        else
            $display("tb_first_fit_free_list_allocator_core: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ffa_pkg.sv
design/ffa_ram.sv
design/first_fit_free_list_allocator_core.sv
design/ffa_checker.sv
verif/tb_first_fit_free_list_allocator_core.sv
